// File: sv/motion_interp_pixel_blend_unit_assert.svh
// Assertion macros for the blend unit; only the mix stage file includes them.
// MIP_ASSERT is disabled while reset is high; MIP_ASSERT_NORST also checks during reset.
`ifndef MOTION_INTERP_PIXEL_BLEND_UNIT_ASSERT_SVH
`define MOTION_INTERP_PIXEL_BLEND_UNIT_ASSERT_SVH
`ifndef SYNTH
`define MIP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MIP_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MIP_ASSERT(lbl, clk, rst, prop, msg)
`define MIP_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// File: sv/mip_pkg.sv
package mip_pkg;

   localparam int PIX_W  = 16;
   localparam int MASK_W = 9;

   // Full weight of a mask or of the time position.
   localparam logic [MASK_W-1:0] FULL_WEIGHT = 9'd256;
   // Rounding constant added before the shifts by eight, but for the one in the temporal mix.
   localparam logic [8:0] ROUND_ADD = 9'd256;

   // Blend mode codes. Code 3 behaves as the plain fetch.
   localparam logic [1:0] MODE_BLEND  = 2'd0;
   localparam logic [1:0] MODE_MEDIAN = 2'd1;
   localparam logic [1:0] MODE_FETCH  = 2'd2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLEND_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_WEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDE_PIXELS = 2'd2;
   localparam int CSR_DATA_W = 9;

   // Configuration as seen by the datapath; the time weight is already saturated.
   typedef struct packed {
      logic [1:0]        mode;
      logic [MASK_W-1:0] tw;
      logic              wide;
   } mip_cfg_type;

   // Front end to combine stage.
   typedef struct packed {
      mip_cfg_type       cfg;
      logic [PIX_W-1:0]  f;
      logic [MASK_W-1:0] mf;
      logic [MASK_W-1:0] mb;
      logic [23:0]       fkeep;
      logic [23:0]       bkeep;
      logic [23:0]       sa;
      logic [23:0]       sb;
      logic [23:0]       mdb;
      logic [23:0]       mdf;
   } mip_mid_type;

   // Combine stage to temporal mix.
   typedef struct packed {
      mip_cfg_type      cfg;
      logic [PIX_W-1:0] f;
      logic [16:0]      t1;
      logic [16:0]      t2;
   } mip_blend_type;

endpackage

// File: sv/mip_front.sv
module mip_front
   import mip_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mip_cfg_type       cfg,
   input  logic              up_valid,
   output logic              up_ready,
   input  logic [PIX_W-1:0]  fwd_pixel,
   input  logic [PIX_W-1:0]  bwd_pixel,
   input  logic [PIX_W-1:0]  fwd_colocated,
   input  logic [PIX_W-1:0]  bwd_colocated,
   input  logic [PIX_W-1:0]  fwd_extra_pixel,
   input  logic [PIX_W-1:0]  bwd_extra_pixel,
   input  logic [MASK_W-1:0] fwd_mask,
   input  logic [MASK_W-1:0] bwd_mask,
   output logic              dn_valid,
   input  logic              dn_ready,
   output mip_mid_type       dn_data
);

   // Stage 1: pixel width reduction, mask saturation, keep and fallback products, medians.
   logic              s1_valid_ff;
   logic              s1_ready;
   mip_cfg_type       s1_cfg_ff;
   logic [PIX_W-1:0]  s1_f_ff, s1_f_in;
   logic [MASK_W-1:0] s1_mf_ff, s1_mf_in, s1_mb_ff, s1_mb_in;
   logic [23:0]       s1_fkeep_ff, s1_fkeep_in, s1_bkeep_ff, s1_bkeep_in;
   logic [23:0]       s1_cf_ff, s1_cf_in, s1_cb_ff, s1_cb_in;
   logic [PIX_W-1:0]  s1_medb_ff, s1_medb_in, s1_medf_ff, s1_medf_in;

   // Stage 2.
   logic              s2_valid_ff;
   logic              s2_ready;
   mip_mid_type       s2_data_ff, s2_data_in;

   function automatic logic [PIX_W-1:0] reduce_pix(input logic [PIX_W-1:0] p, input logic wide);
      reduce_pix = wide ? p : {8'd0, p[7:0]};
   endfunction

   function automatic logic [MASK_W-1:0] sat_mask(input logic [MASK_W-1:0] m);
      sat_mask = (m > FULL_WEIGHT) ? FULL_WEIGHT : m;
   endfunction

   always_comb begin
      logic [PIX_W-1:0] f, b, f0, b0, ff, bb, lo, hi;
      f  = reduce_pix(fwd_pixel, cfg.wide);
      b  = reduce_pix(bwd_pixel, cfg.wide);
      f0 = reduce_pix(fwd_colocated, cfg.wide);
      b0 = reduce_pix(bwd_colocated, cfg.wide);
      ff = reduce_pix(fwd_extra_pixel, cfg.wide);
      bb = reduce_pix(bwd_extra_pixel, cfg.wide);
      s1_f_in  = f;
      s1_mf_in = sat_mask(fwd_mask);
      s1_mb_in = sat_mask(bwd_mask);
      s1_fkeep_in = 24'(f) * 24'(FULL_WEIGHT - s1_mf_in);
      s1_bkeep_in = 24'(b) * 24'(FULL_WEIGHT - s1_mb_in);
      s1_cf_in = 24'(f0) * 24'(s1_mb_in);
      s1_cb_in = 24'(b0) * 24'(s1_mf_in);
      // Median of three: clamp the extra candidate into the range spanned by B and F.
      lo = (b < f) ? b : f;
      hi = (b > f) ? b : f;
      s1_medb_in = (bb < hi) ? ((bb > lo) ? bb : lo) : hi;
      s1_medf_in = (ff < hi) ? ((ff > lo) ? ff : lo) : hi;
   end

   assign up_ready = !s1_valid_ff || s2_ready;
   assign s1_ready = up_ready;
   assign s2_ready = !s2_valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && up_valid) begin
         s1_cfg_ff   <= cfg;
         s1_f_ff     <= s1_f_in;
         s1_mf_ff    <= s1_mf_in;
         s1_mb_ff    <= s1_mb_in;
         s1_fkeep_ff <= s1_fkeep_in;
         s1_bkeep_ff <= s1_bkeep_in;
         s1_cf_ff    <= s1_cf_in;
         s1_cb_ff    <= s1_cb_in;
         s1_medb_ff  <= s1_medb_in;
         s1_medf_ff  <= s1_medf_in;
      end
   end

   always_comb begin
      s2_data_in.cfg   = s1_cfg_ff;
      s2_data_in.f     = s1_f_ff;
      s2_data_in.mf    = s1_mf_ff;
      s2_data_in.mb    = s1_mb_ff;
      s2_data_in.fkeep = s1_fkeep_ff;
      s2_data_in.bkeep = s1_bkeep_ff;
      s2_data_in.sa    = s1_bkeep_ff + s1_cf_ff;
      s2_data_in.sb    = s1_fkeep_ff + s1_cb_ff;
      s2_data_in.mdb   = 24'(s1_medb_ff) * 24'(s1_mf_ff);
      s2_data_in.mdf   = 24'(s1_medf_ff) * 24'(s1_mb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && s1_valid_ff) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign dn_valid = s2_valid_ff;
   assign dn_data  = s2_data_ff;

endmodule

// File: sv/mip_comb.sv
module mip_comb
   import mip_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          up_valid,
   output logic          up_ready,
   input  mip_mid_type   up_data,
   output logic          dn_valid,
   input  logic          dn_ready,
   output mip_blend_type dn_data
);

   // Stage 3: occlusion fallback products and the median-mode side values.
   logic             s3_valid_ff;
   logic             s4_ready;
   mip_cfg_type      s3_cfg_ff;
   logic [PIX_W-1:0] s3_f_ff;
   logic [31:0]      s3_pa_prod_ff, s3_pa_prod_in, s3_pb_prod_ff, s3_pb_prod_in;
   logic [16:0]      s3_t1m_ff, s3_t1m_in, s3_t2m_ff, s3_t2m_in;
   logic [23:0]      s3_fkeep_ff, s3_bkeep_ff;

   // Stage 4.
   logic             s4_valid_ff;
   mip_blend_type    s4_data_ff, s4_data_in;

   always_comb begin
      logic [25:0] sum1, sum2;
      s3_pa_prod_in = 32'(up_data.mf) * 32'(up_data.sa);
      s3_pb_prod_in = 32'(up_data.mb) * 32'(up_data.sb);
      sum1 = 26'(up_data.mdb) + 26'(up_data.fkeep) + 26'(ROUND_ADD);
      sum2 = 26'(up_data.mdf) + 26'(up_data.bkeep) + 26'(ROUND_ADD);
      s3_t1m_in = sum1[24:8];
      s3_t2m_in = sum2[24:8];
   end

   assign up_ready = !s3_valid_ff || s4_ready;
   assign s4_ready = !s4_valid_ff || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (up_ready) begin
         s3_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         s3_cfg_ff     <= up_data.cfg;
         s3_f_ff       <= up_data.f;
         s3_pa_prod_ff <= s3_pa_prod_in;
         s3_pb_prod_ff <= s3_pb_prod_in;
         s3_t1m_ff     <= s3_t1m_in;
         s3_t2m_ff     <= s3_t2m_in;
         s3_fkeep_ff   <= up_data.fkeep;
         s3_bkeep_ff   <= up_data.bkeep;
      end
   end

   // Stage 4 logic: round the fallback terms, add them to the kept part, select by mode.
   always_comb begin
      logic [32:0] ra, rb;
      logic [25:0] sum1, sum2;
      ra   = 33'(s3_pa_prod_ff) + 33'(ROUND_ADD);
      rb   = 33'(s3_pb_prod_ff) + 33'(ROUND_ADD);
      sum1 = 26'(s3_fkeep_ff) + 26'(ra[31:8]) + 26'(ROUND_ADD);
      sum2 = 26'(s3_bkeep_ff) + 26'(rb[31:8]) + 26'(ROUND_ADD);
      s4_data_in.cfg = s3_cfg_ff;
      s4_data_in.f   = s3_f_ff;
      if (s3_cfg_ff.mode == MODE_BLEND) begin
         s4_data_in.t1 = sum1[24:8];
         s4_data_in.t2 = sum2[24:8];
      end else begin
         s4_data_in.t1 = s3_t1m_ff;
         s4_data_in.t2 = s3_t2m_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_ready) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s4_ready && s3_valid_ff) begin
         s4_data_ff <= s4_data_in;
      end
   end

   assign dn_valid = s4_valid_ff;
   assign dn_data  = s4_data_ff;

endmodule

// File: sv/mip_mix.sv
`include "motion_interp_pixel_blend_unit_assert.svh"

module mip_mix
   import mip_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             up_valid,
   output logic             up_ready,
   input  mip_blend_type    up_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [PIX_W-1:0] out_pixel
);

   // Stage 5: temporal weighting products.
   logic             s5_valid_ff;
   logic             s6_ready;
   mip_cfg_type      s5_cfg_ff;
   logic [PIX_W-1:0] s5_f_ff;
   logic [25:0]      s5_w1_ff, s5_w1_in, s5_w2_ff, s5_w2_in;

   // Stage 6: output register.
   logic             out_valid_ff;
   logic             out_wide_ff;
   logic [PIX_W-1:0] out_pixel_ff, out_pixel_in;

   always_comb begin
      s5_w1_in = 26'(up_data.t1) * 26'(FULL_WEIGHT - up_data.cfg.tw);
      s5_w2_in = 26'(up_data.t2) * 26'(up_data.cfg.tw);
   end

   assign up_ready = !s5_valid_ff || s6_ready;
   assign s6_ready = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (up_ready) begin
         s5_valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         s5_cfg_ff <= up_data.cfg;
         s5_f_ff   <= up_data.f;
         s5_w1_ff  <= s5_w1_in;
         s5_w2_ff  <= s5_w2_in;
      end
   end

   // A blend result of zero wraps to all ones of the pixel width after the subtraction.
   always_comb begin
      logic [26:0] total;
      logic [18:0] dec;
      total = 27'(s5_w1_ff) + 27'(s5_w2_ff);
      dec   = total[26:8] - 19'd1;
      case (s5_cfg_ff.mode) inside
         MODE_BLEND, MODE_MEDIAN: begin
            out_pixel_in = s5_cfg_ff.wide ? dec[15:0] : {8'd0, dec[7:0]};
         end
         default: begin
            out_pixel_in = s5_f_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s6_ready) begin
         out_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s6_ready && s5_valid_ff) begin
         out_pixel_ff <= out_pixel_in;
         out_wide_ff  <= s5_cfg_ff.wide;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_pixel_ff;

   `MIP_ASSERT(a_narrow_high_zero, clock, reset, out_valid_ff && !out_wide_ff |-> out_pixel_ff[15:8] == 8'd0, "narrow pixel has high byte set")
   `MIP_ASSERT(a_stall_keeps_s5, clock, reset, s5_valid_ff && !s6_ready |=> s5_valid_ff && $stable(s5_w1_ff) && $stable(s5_w2_ff), "stalled item lost in mix stage")
   `MIP_ASSERT_NORST(a_reset_empties, clock, reset |=> !s5_valid_ff && !out_valid_ff, "pipeline not empty after reset")

endmodule

// File: sv/motion_interp_pixel_blend_unit.sv
// Per-pixel blend of a motion-compensated frame interpolator. Each item carries the forward and
// backward compensated pixels, the co-located pixels, the extra median candidates and the two
// occlusion masks, and yields one interpolated pixel. The datapath is a six-stage pipeline that
// accepts one item every clock while the result side is ready; the rate is set by the pipeline
// registers alone, since every multiplier and adder is used once per item. Ready is formed per
// stage, so a stalled output register only blocks the input once every stage holds an item,
// and empty stages keep accepting meanwhile. Configuration registers are written through the
// csr port; the user must write them only while no item is in flight, which the block does not
// enforce. Each item captures blend mode, time weight and pixel width as it enters.
module motion_interp_pixel_blend_unit
   import mip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   // Configuration write port.
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,

   // Input item channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [PIX_W-1:0]      req_fwd_pixel,
   input  logic [PIX_W-1:0]      req_bwd_pixel,
   input  logic [PIX_W-1:0]      req_fwd_colocated,
   input  logic [PIX_W-1:0]      req_bwd_colocated,
   input  logic [PIX_W-1:0]      req_fwd_extra_pixel,
   input  logic [PIX_W-1:0]      req_bwd_extra_pixel,
   input  logic [MASK_W-1:0]     req_fwd_mask,
   input  logic [MASK_W-1:0]     req_bwd_mask,

   // Result item channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [PIX_W-1:0]      rsp_out_pixel
);

   // Configuration registers, reset to occlusion blend, mid-way time and 8-bit pixels.
   logic [1:0]        blend_mode_ff;
   logic [MASK_W-1:0] time_weight_ff;
   logic              wide_pixels_ff;
   mip_cfg_type       cfg;

   // Handshakes between the pipeline sections.
   logic              mid_valid, mid_ready;
   mip_mid_type       mid_data;
   logic              blend_valid, blend_ready;
   mip_blend_type     blend_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_mode_ff  <= MODE_BLEND;
         time_weight_ff <= 9'd128;
         wide_pixels_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BLEND_MODE:  blend_mode_ff  <= csr_write_data[1:0];
            CSR_TIME_WEIGHT: time_weight_ff <= csr_write_data[MASK_W-1:0];
            CSR_WIDE_PIXELS: wide_pixels_ff <= csr_write_data[0];
            default: begin
               // Writes to unassigned indexes are dropped.
            end
         endcase
      end
   end

   // Time positions beyond a full frame are held at a full frame.
   always_comb begin
      cfg.mode = blend_mode_ff;
      cfg.tw   = (time_weight_ff > FULL_WEIGHT) ? FULL_WEIGHT : time_weight_ff;
      cfg.wide = wide_pixels_ff;
   end

   // Stages 1 and 2: input reduction, keep products, medians and side sums.
   mip_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .up_valid        (req_valid),
      .up_ready        (req_ready),
      .fwd_pixel       (req_fwd_pixel),
      .bwd_pixel       (req_bwd_pixel),
      .fwd_colocated   (req_fwd_colocated),
      .bwd_colocated   (req_bwd_colocated),
      .fwd_extra_pixel (req_fwd_extra_pixel),
      .bwd_extra_pixel (req_bwd_extra_pixel),
      .fwd_mask        (req_fwd_mask),
      .bwd_mask        (req_bwd_mask),
      .dn_valid        (mid_valid),
      .dn_ready        (mid_ready),
      .dn_data         (mid_data)
   );

   // Stages 3 and 4: occlusion fallback and per-side rounding.
   mip_comb u_comb (
      .clock    (clock),
      .reset    (reset),
      .up_valid (mid_valid),
      .up_ready (mid_ready),
      .up_data  (mid_data),
      .dn_valid (blend_valid),
      .dn_ready (blend_ready),
      .dn_data  (blend_data)
   );

   // Stages 5 and 6: temporal mix and the output register.
   mip_mix u_mix (
      .clock     (clock),
      .reset     (reset),
      .up_valid  (blend_valid),
      .up_ready  (blend_ready),
      .up_data   (blend_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_pixel (rsp_out_pixel)
   );

endmodule

// File: dv/tb_motion_interp_pixel_blend_unit.sv
`timescale 1ns / 1ps

module tb_motion_interp_pixel_blend_unit;
   import mip_pkg::*;

   // Pixel masks for the two pixel widths.
   localparam logic [63:0] PIX8_MASK  = 64'hFF;
   localparam logic [63:0] PIX16_MASK = 64'hFFFF;

   // Mode code 3 has no name in the package; it must act as the plain fetch.
   localparam logic [1:0] MODE_FETCH_ALT = 2'd3;
   // Register index 3 is not mapped; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // The pipeline is six stages deep, so a short tail is enough to catch stray results.
   localparam int END_TAIL      = 32;
   // The watchdog limit sits well above the length of the long receiver hold.
   localparam int RX_HOLD_LEN   = 300;
   localparam int STALL_LIMIT   = 5000;
   localparam int SEGMENTS      = 18;
   localparam int SEGMENT_ITEMS = 100;

   // One input item, field by field as the ports carry it.
   typedef struct {
      logic [PIX_W-1:0]  fwd_pixel;
      logic [PIX_W-1:0]  bwd_pixel;
      logic [PIX_W-1:0]  fwd_colocated;
      logic [PIX_W-1:0]  bwd_colocated;
      logic [PIX_W-1:0]  fwd_extra_pixel;
      logic [PIX_W-1:0]  bwd_extra_pixel;
      logic [MASK_W-1:0] fwd_mask;
      logic [MASK_W-1:0] bwd_mask;
   } pix_item_type;

   // The checker keeps its own copy of the three registers, computes the interpolated
   // pixel for every accepted item and compares the results in order of arrival.
   class blend_pixel_checker;
      logic [1:0]        mode;
      logic [MASK_W-1:0] tw;
      logic              wide;
      logic [PIX_W-1:0]  expected_pixels[$];
      int                mismatch_count;

      function new();
         mode = MODE_BLEND;
         tw = 9'd128;
         wide = 1'b0;
         mismatch_count = 0;
      endfunction

      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BLEND_MODE:  mode = data[1:0];
            CSR_TIME_WEIGHT: tw = data[MASK_W-1:0];
            CSR_WIDE_PIXELS: wide = data[0];
            default: ;
         endcase
      endfunction

      // All arithmetic is done in 64 bits, so every product is exact.
      function logic [PIX_W-1:0] blend_pixel(pix_item_type it);
         logic [63:0] pm, f, b, f0, b0, ff, bb, mf, mb, t, inv;
         logic [63:0] fkeep, bkeep, pa, pb, t1, t2, lo, hi, medb, medf, mix, res;
         pm = wide ? PIX16_MASK : PIX8_MASK;
         f = it.fwd_pixel & pm;
         b = it.bwd_pixel & pm;
         f0 = it.fwd_colocated & pm;
         b0 = it.bwd_colocated & pm;
         ff = it.fwd_extra_pixel & pm;
         bb = it.bwd_extra_pixel & pm;
         mf = (it.fwd_mask > FULL_WEIGHT) ? FULL_WEIGHT : it.fwd_mask;
         mb = (it.bwd_mask > FULL_WEIGHT) ? FULL_WEIGHT : it.bwd_mask;
         t = (tw > FULL_WEIGHT) ? FULL_WEIGHT : tw;
         inv = FULL_WEIGHT - t;
         case (mode)
            MODE_BLEND: begin
               // Each side leans toward the other side as its mask grows.
               fkeep = f * (FULL_WEIGHT - mf);
               bkeep = b * (FULL_WEIGHT - mb);
               pa = (mf * (bkeep + mb * f0) + ROUND_ADD) >> 8;
               pb = (mb * (fkeep + mf * b0) + ROUND_ADD) >> 8;
               t1 = (fkeep + pa + ROUND_ADD) >> 8;
               t2 = (bkeep + pb + ROUND_ADD) >> 8;
            end
            MODE_MEDIAN: begin
               // The extra candidates are clamped between the two compensated pixels.
               lo = (b < f) ? b : f;
               hi = (b > f) ? b : f;
               medb = (bb < hi) ? bb : hi;
               if (medb < lo) medb = lo;
               medf = (ff < hi) ? ff : hi;
               if (medf < lo) medf = lo;
               t1 = (medb * mf + f * (FULL_WEIGHT - mf) + ROUND_ADD) >> 8;
               t2 = (medf * mb + b * (FULL_WEIGHT - mb) + ROUND_ADD) >> 8;
            end
            default: return f[PIX_W-1:0];
         endcase
         mix = (t1 * inv + t2 * t) >> 8;
         res = (mix - 64'd1) & pm;
         return res[PIX_W-1:0];
      endfunction

      function void note_item(pix_item_type it);
         expected_pixels.push_back(blend_pixel(it));
      endfunction

      function void check_result(logic [PIX_W-1:0] got);
         logic [PIX_W-1:0] want;
         if (expected_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: out_pixel %h with nothing pending", got);
            return;
         end
         want = expected_pixels.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("out_pixel mismatch: expected %h, actual %h", want, got);
         end
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction
   endclass

   // Every input of the block starts at a known value; reset is high from time zero.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [PIX_W-1:0]      req_fwd_pixel = '0;
   logic [PIX_W-1:0]      req_bwd_pixel = '0;
   logic [PIX_W-1:0]      req_fwd_colocated = '0;
   logic [PIX_W-1:0]      req_bwd_colocated = '0;
   logic [PIX_W-1:0]      req_fwd_extra_pixel = '0;
   logic [PIX_W-1:0]      req_bwd_extra_pixel = '0;
   logic [MASK_W-1:0]     req_fwd_mask = '0;
   logic [MASK_W-1:0]     req_bwd_mask = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [PIX_W-1:0]      rsp_out_pixel;

   blend_pixel_checker pix_check = new();

   // Idle rates in percent for both sides, and a request for a long receiver hold.
   int req_idle_pct = 10;
   int rsp_idle_pct = 54;
   int rx_hold_request = 0;
   int rx_hold_left = 0;
   int stall_count = 0;

   // Corner items used by the directed part, and the directed register settings.
   pix_item_type      corner_items[4];
   logic [1:0]        dir_mode[6] = '{MODE_BLEND, MODE_MEDIAN, MODE_MEDIAN, MODE_FETCH,
                                      MODE_FETCH_ALT, MODE_BLEND};
   logic [MASK_W-1:0] dir_tw[6]   = '{9'd0, 9'd256, 9'd511, 9'd128, 9'd128, 9'd300};
   logic              dir_wide[6] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

   motion_interp_pixel_blend_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_fwd_pixel       (req_fwd_pixel),
      .req_bwd_pixel       (req_bwd_pixel),
      .req_fwd_colocated   (req_fwd_colocated),
      .req_bwd_colocated   (req_bwd_colocated),
      .req_fwd_extra_pixel (req_fwd_extra_pixel),
      .req_bwd_extra_pixel (req_bwd_extra_pixel),
      .req_fwd_mask        (req_fwd_mask),
      .req_bwd_mask        (req_bwd_mask),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_pixel       (rsp_out_pixel)
   );

   // 4 ns clock: 2 ns high, 2 ns low.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side. Ready drops at the programmed idle rate. When a long hold is requested,
   // ready stays low until the requested hold is counted down here, so that the pipeline fills and
   // the input side backs up while the sender keeps offering items.
   always @(posedge clock) begin
      if (rx_hold_request != 0) begin
         rx_hold_left = rx_hold_request;
         rx_hold_request = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rx_hold_left != 0) begin
         rsp_ready <= 1'b0;
         rx_hold_left = rx_hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Result monitor. Outputs are sampled at the edge, before any update of this step
   // takes effect, so the values seen are those of the accepting cycle.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         pix_check.check_result(rsp_out_pixel);
   end

   // Watchdog: ends the run when neither channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // One register write. The enable is high for exactly one edge, and the checker's copy
   // is updated once that edge has passed.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pix_check.note_config(idx, data);
   endtask

   // Writes all three registers. The bits above a narrow register's width are random,
   // since the block must ignore them.
   task automatic write_config(input logic [1:0] mode, input logic [MASK_W-1:0] tw,
                               input logic wide);
      write_reg(CSR_BLEND_MODE, {7'($urandom_range(127)), mode});
      write_reg(CSR_TIME_WEIGHT, tw);
      write_reg(CSR_WIDE_PIXELS, {8'($urandom_range(255)), wide});
   endtask

   // Offers a run of items back to back, with random gaps at the sender's idle rate.
   // Valid is raised once per item and only lowered for a gap or after the last item,
   // so it never gets two assignments in one step. The run ends once every result of
   // it has come back, which leaves the block idle for the next register write.
   task automatic send_run(input pix_item_type run[$]);
      int gap;
      foreach (run[i]) begin
         req_valid <= 1'b1;
         req_fwd_pixel <= run[i].fwd_pixel;
         req_bwd_pixel <= run[i].bwd_pixel;
         req_fwd_colocated <= run[i].fwd_colocated;
         req_bwd_colocated <= run[i].bwd_colocated;
         req_fwd_extra_pixel <= run[i].fwd_extra_pixel;
         req_bwd_extra_pixel <= run[i].bwd_extra_pixel;
         req_fwd_mask <= run[i].fwd_mask;
         req_bwd_mask <= run[i].bwd_mask;
         do @(posedge clock); while (!req_ready);
         pix_check.note_item(run[i]);
         if (i == run.size() - 1) begin
            req_valid <= 1'b0;
         end else begin
            gap = 0;
            while ($urandom_range(99) < req_idle_pct) gap++;
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
      while (pix_check.pending() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   // Pixels lean toward the extremes now and then; all 16 bits are driven even in
   // 8-bit mode, where the block must drop the upper byte.
   function automatic logic [PIX_W-1:0] rand_pixel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return PIX_W'($urandom_range(255));
         default: return PIX_W'($urandom());
      endcase
   endfunction

   // Masks are mostly in range, with the full weight and saturating values mixed in.
   function automatic logic [MASK_W-1:0] rand_mask();
      case ($urandom_range(7))
         0: return '0;
         1: return FULL_WEIGHT;
         2: return MASK_W'($urandom_range(511, 257));
         default: return MASK_W'($urandom_range(256));
      endcase
   endfunction

   // A time weight for one segment: zero, full, above full, or anything in range.
   function automatic logic [MASK_W-1:0] rand_time_weight();
      case ($urandom_range(5))
         0: return '0;
         1: return FULL_WEIGHT;
         2: return MASK_W'($urandom_range(511, 257));
         default: return MASK_W'($urandom_range(256));
      endcase
   endfunction

   initial begin
      pix_item_type run[$];
      pix_item_type it;
      logic [1:0] seg_modes[4];

      seg_modes = '{MODE_BLEND, MODE_MEDIAN, MODE_FETCH, MODE_FETCH_ALT};

      // All zero with open masks; all ones with full occlusion; opposite extremes with
      // the forward mask above its range so the median clamps hit both bounds; and a
      // mixed item with the extras inside the median range and one mask saturating.
      corner_items[0] = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          9'd0, 9'd0};
      corner_items[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                          9'd256, 9'd256};
      corner_items[2] = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF,
                          9'd511, 9'd0};
      corner_items[3] = '{16'h1234, 16'hABCD, 16'hFFFF, 16'h00FF, 16'h5555, 16'h8000,
                          9'd128, 9'd300};

      // Reset is held from time zero and released at an edge.
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. First the reset values of the registers are exercised unchanged.
      run = {corner_items[0], corner_items[1], corner_items[2], corner_items[3]};
      send_run(run);

      // A write to the unmapped index must not disturb the configuration.
      write_reg(CSR_SPARE, '1);
      run = {corner_items[3]};
      send_run(run);

      // Each mode, including the unnamed fourth code, at zero, full and saturated time
      // weights and both pixel widths.
      for (int d = 0; d < 6; d++) begin
         write_config(dir_mode[d], dir_tw[d], dir_wide[d]);
         run = {corner_items[1], corner_items[2], corner_items[3]};
         send_run(run);
      end

      // Random part. Items are independent, so each segment gets a fresh configuration
      // and a burst of random items. The idle profile changes every six segments: the
      // sender lightly loaded and the receiver heavily, then the reverse, then neither.
      // The first segment of each profile starts with a long receiver hold.
      for (int s = 0; s < SEGMENTS; s++) begin
         if (s == SEGMENTS / 3) begin
            req_idle_pct = 54;
            rsp_idle_pct = 10;
         end else if (s == 2 * SEGMENTS / 3) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         write_config(seg_modes[s % 4], rand_time_weight(), 1'($urandom_range(1)));
         run.delete();
         for (int i = 0; i < SEGMENT_ITEMS; i++) begin
            it.fwd_pixel = rand_pixel();
            it.bwd_pixel = rand_pixel();
            it.fwd_colocated = rand_pixel();
            it.bwd_colocated = rand_pixel();
            it.fwd_extra_pixel = rand_pixel();
            it.bwd_extra_pixel = rand_pixel();
            it.fwd_mask = rand_mask();
            it.bwd_mask = rand_mask();
            run.push_back(it);
         end
         if (s % (SEGMENTS / 3) == 0)
            rx_hold_request = RX_HOLD_LEN;
         send_run(run);
      end

      // Every result is in; wait out the end tail so the pipeline can show any stray one.
      repeat (END_TAIL) @(posedge clock);
      if (pix_check.mismatch_count == 0 && pix_check.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
